[hdl/assert_macros.svh]
// Assertion macros for the RTL of the deque block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/cdq_pkg.sv]
// ---------------------------------------------------------------------------
// cdq_pkg
// Types and constants of the circular deque: operation and status codes,
// field widths and the command word broadcast to the cell row.
// ---------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

	localparam int MAX_ENTRIES_DEF = 15;
	localparam int CAP_W           = 4;
	localparam int VAL_W           = 32;
	localparam int OP_W            = 2;
	localparam int ST_W            = 2;
	localparam int CAP_RESET       = 15;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_POP_FRONT  = 2'd1,
		OP_PUSH_BACK  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// One command for the whole row; at most one operation bit is set.
	typedef struct packed {
		logic clear;
		logic push_front;
		logic pop_front;
		logic push_back;
		logic pop_back;
	} cell_cmd_t;

endpackage

`default_nettype wire

[hdl/cdq_cell.sv]
// ---------------------------------------------------------------------------
// cdq_cell
// One position of the deque. The front lives in cell 0; pushes and pops at
// the front shift the whole row, the back is the last occupied cell.
// ---------------------------------------------------------------------------
`default_nettype none

module cdq_cell
	import cdq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cell_cmd_t        cmd,
	input  wire logic [VAL_W-1:0] value,
	input  wire logic [VAL_W-1:0] left_data,
	input  wire logic             left_occ,
	input  wire logic [VAL_W-1:0] right_data,
	input  wire logic             right_occ,
	output logic      [VAL_W-1:0] data_q,
	output logic                  occ_q,
	output logic                  is_last
);

	// This cell holds the back element when its right neighbor is free.
	assign is_last = occ_q & ~right_occ;

	always_ff @(posedge clk) begin
		priority if (cmd.push_front) begin
			data_q <= left_data;
		end else if (cmd.pop_front) begin
			data_q <= right_data;
		end else if (cmd.push_back && !occ_q && left_occ) begin
			data_q <= value;
		end else begin
			data_q <= data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			priority if (cmd.clear) begin
				occ_q <= 1'b0;
			end else if (cmd.push_front) begin
				occ_q <= left_occ;
			end else if (cmd.pop_front) begin
				occ_q <= right_occ;
			end else if (cmd.push_back) begin
				occ_q <= occ_q | left_occ;
			end else if (cmd.pop_back) begin
				occ_q <= occ_q & right_occ;
			end else begin
				occ_q <= occ_q;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/circular_deque_unit.sv]
// ---------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue of signed 32-bit values with a configurable capacity,
// built as a row of shifting cells with one status beat per operation.
// ---------------------------------------------------------------------------
//  Channel  Direction  Signals                      Content
//  s_*      in         tvalid tready tdata tuser    tdata: value, tuser: op
//  m_*      out        tvalid tready tdata tuser    tdata: value_out, tuser: status
//  cfg_*    in         we wdata                     capacity
//
// Each beat is decided in the cycle it is accepted; its result sits in the
// output register from the next cycle on, so one operation per cycle passes while the output does not stall.
// The occupancy bits of the cell row set the full and empty decisions.
// A capacity write empties the deque; reset empties it and sets capacity 15.
// While the result waits for m_tready a new beat is taken only as it leaves.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module circular_deque_unit
	import cdq_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [VAL_W-1:0]  s_tdata,   // [31:0] value
	input  wire logic [OP_W-1:0]   s_tuser,   // [1:0] op
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [VAL_W-1:0]  m_tdata,   // [31:0] value_out
	output logic      [ST_W-1:0]   m_tuser,   // [1:0] status
	input  wire logic              cfg_we,
	input  wire logic [CAP_W-1:0]  cfg_wdata
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ENTRIES);
	localparam logic [CMP_W-1:0] RESET_CAP =
		(CAP_RESET > MAX_ENTRIES) ? CMP_W'(MAX_ENTRIES) : CMP_W'(CAP_RESET);

	// One-hot mark of the cell that holds the last usable entry; all zero for capacity 0.
	function automatic logic [MAX_ENTRIES-1:0] limit_of(input logic [CMP_W-1:0] cap);
		logic [MAX_ENTRIES-1:0] lim;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			lim[i] = (cap == CMP_W'(i + 1));
		end
		return lim;
	endfunction

	logic [MAX_ENTRIES-1:0] limit_q;
	logic                   cap_zero_q;
	logic [CMP_W-1:0]       cap_in;
	logic [CMP_W-1:0]       cap_eff;

	logic [VAL_W-1:0]       cell_data [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] occ;
	logic [MAX_ENTRIES-1:0] last;
	logic [VAL_W-1:0]       last_data;

	op_t                    op;
	status_t                status;
	logic                   accept;
	logic                   full;
	logic                   empty;
	logic                   ok;
	logic [VAL_W-1:0]       pop_value;
	cell_cmd_t              cmd;

	logic                   m_tvalid_q;
	logic [VAL_W-1:0]       m_tdata_q;
	logic [ST_W-1:0]        m_tuser_q;

	// Capacity, clamped to the cell count.
	assign cap_in  = CMP_W'(cfg_wdata);
	assign cap_eff = (cap_in > MAX_CMP) ? MAX_CMP : cap_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= limit_of(RESET_CAP);
			cap_zero_q <= 1'b0;
		end else if (cfg_we) begin
			limit_q    <= limit_of(cap_eff);
			cap_zero_q <= (cap_eff == '0);
		end
	end

	assign s_tready = ~m_tvalid_q | m_tready;
	assign accept   = s_tvalid & s_tready;
	assign op       = op_t'(s_tuser);

	assign empty = ~occ[0];
	assign full  = cap_zero_q | (|(occ & limit_q));

	always_comb begin
		unique case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: status = full ? ST_FULL : ST_OK;
			OP_POP_FRONT, OP_POP_BACK:   status = empty ? ST_EMPTY : ST_OK;
			default:                     status = ST_OK;
		endcase
	end

	assign ok = accept & (status == ST_OK);

	always_comb begin
		cmd            = '0;
		cmd.clear      = cfg_we;
		cmd.push_front = ok & (op == OP_PUSH_FRONT);
		cmd.pop_front  = ok & (op == OP_POP_FRONT);
		cmd.push_back  = ok & (op == OP_PUSH_BACK);
		cmd.pop_back   = ok & (op == OP_POP_BACK);
	end

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic [VAL_W-1:0] left_data;
		logic             left_occ;
		logic [VAL_W-1:0] right_data;
		logic             right_occ;

		// The input beat enters at the front; nothing lies past the last cell.
		if (i == 0) begin : g_head
			assign left_data = s_tdata;
			assign left_occ  = 1'b1;
		end else begin : g_body
			assign left_data = cell_data[i-1];
			assign left_occ  = occ[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign right_data = '0;
			assign right_occ  = 1'b0;
		end else begin : g_inner
			assign right_data = cell_data[i+1];
			assign right_occ  = occ[i+1];
		end

		cdq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.value      (s_tdata),
			.left_data  (left_data),
			.left_occ   (left_occ),
			.right_data (right_data),
			.right_occ  (right_occ),
			.data_q     (cell_data[i]),
			.occ_q      (occ[i]),
			.is_last    (last[i])
		);
	end

	// At most one cell flags itself as the back, so an OR picks its data.
	always_comb begin
		last_data = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			last_data = last_data | (last[i] ? cell_data[i] : '0);
		end
	end

	always_comb begin
		pop_value = '0;
		if (status == ST_OK) begin
			unique case (op)
				OP_POP_FRONT:               pop_value = cell_data[0];
				OP_POP_BACK:                pop_value = last_data;
				OP_PUSH_FRONT, OP_PUSH_BACK: pop_value = '0;
				default:                    pop_value = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= pop_value;
			m_tuser_q <= status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Occupied cells always form one run starting at cell 0.
	`ASSERT_CLK(a_occ_contiguous, clk, arst_n,
		(occ & (occ + MAX_ENTRIES'(1))) == '0, "occupancy is not contiguous from the front")
	`ASSERT_CLK(a_push_fills, clk, arst_n,
		(cmd.push_front || cmd.push_back) && !cfg_we |=> occ[0],
		"deque empty after a successful insert")
	`ASSERT_CLK(a_cfg_empties, clk, arst_n, cfg_we |=> occ == '0,
		"capacity write left entries behind")
	`ASSERT_CLK(a_refused_holds, clk, arst_n,
		accept && (status != ST_OK) && !cfg_we |=> $stable(occ),
		"refused operation changed the occupancy")

endmodule

`default_nettype wire

[tb/circular_deque_unit_tb.sv]
// ---------------------------------------------------------------------------
// circular_deque_unit_tb
// Self-checking bench for the circular deque. Operations stream in on the
// slave side and every accepted beat is run through a ring model of the
// deque. The expected status and removed value are compared with each result
// beat. Both sides idle and stall at random, and the capacity is changed
// between phases while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module circular_deque_unit_tb;
	import cdq_pkg::*;

	localparam int          DEPTH       = MAX_ENTRIES_DEF;
	localparam int          RAND_PHASES = 28;
	localparam int          PHASE_OPS   = 50;
	localparam int unsigned CYCLE_LIMIT = 500000;

	typedef struct packed {
		status_t            status;
		logic [VAL_W-1:0]   value;
	} deque_result_t;

	class deque_scoreboard;
		logic [VAL_W-1:0] ring [DEPTH+1];
		int unsigned      front_idx;
		int unsigned      rear_idx;
		int unsigned      slots;
		deque_result_t    expected_q[$];
		int unsigned      errors;
		int unsigned      checked;
		int unsigned      full_seen;
		int unsigned      empty_seen;
		int unsigned      cap_writes;

		function new();
			errors = 0;
			checked = 0;
			full_seen = 0;
			empty_seen = 0;
			cap_writes = 0;
			set_capacity(CAP_RESET);
		endfunction

		function void set_capacity(int unsigned cap);
			slots = ((cap > DEPTH) ? DEPTH : cap) + 1;
			front_idx = 0;
			rear_idx = 0;
		endfunction

		function int unsigned step_up(int unsigned i);
			return (i + 1 >= slots) ? 0 : i + 1;
		endfunction

		function int unsigned step_down(int unsigned i);
			return (i == 0) ? slots - 1 : i - 1;
		endfunction

		function void note_op(op_t op, logic [VAL_W-1:0] v);
			deque_result_t r;
			int unsigned   nxt;
			r.status = ST_OK;
			r.value = '0;
			if (front_idx >= slots) front_idx = 0;
			if (rear_idx >= slots) rear_idx = 0;
			case (op)
				OP_PUSH_FRONT: begin
					nxt = step_down(front_idx);
					if (nxt == rear_idx) begin
						r.status = ST_FULL;
					end else begin
						front_idx = nxt;
						ring[front_idx] = v;
					end
				end
				OP_POP_FRONT: begin
					if (front_idx == rear_idx) begin
						r.status = ST_EMPTY;
					end else begin
						r.value = ring[front_idx];
						front_idx = step_up(front_idx);
					end
				end
				OP_PUSH_BACK: begin
					nxt = step_up(rear_idx);
					if (nxt == front_idx) begin
						r.status = ST_FULL;
					end else begin
						ring[rear_idx] = v;
						rear_idx = nxt;
					end
				end
				default: begin
					if (front_idx == rear_idx) begin
						r.status = ST_EMPTY;
					end else begin
						rear_idx = step_down(rear_idx);
						r.value = ring[rear_idx];
					end
				end
			endcase
			if (r.status == ST_FULL) full_seen++;
			if (r.status == ST_EMPTY) empty_seen++;
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [ST_W-1:0] st, logic [VAL_W-1:0] v);
			deque_result_t r;
			if (expected_q.size() == 0) begin
				$display("%0t: result beat with nothing expected: status %0d value %h",
					$time, st, v);
				errors++;
				return;
			end
			r = expected_q.pop_front();
			checked++;
			if (st !== r.status) begin
				$display("%0t: status mismatch: expected %0d actual %0d",
					$time, r.status, st);
				errors++;
			end
			if (v !== r.value) begin
				$display("%0t: value_out mismatch: expected %h actual %h",
					$time, r.value, v);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [VAL_W-1:0] s_tdata   = '0;
	logic [OP_W-1:0]  s_tuser   = '0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [VAL_W-1:0] m_tdata;
	logic [ST_W-1:0]  m_tuser;
	logic             cfg_we    = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;

	deque_scoreboard  sb;
	logic             calm       = 1'b0;
	int unsigned      stall_left = 0;
	int unsigned      cycle_count = 0;

	circular_deque_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < 30) begin
			stall_left <= gap_len();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// The outgoing result always belongs to an earlier beat, so it is
	// checked before the beat accepted at the same edge is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata);
			if (s_tvalid && s_tready)
				sb.note_op(op_t'(s_tuser), s_tdata);
		end
	end

	task automatic send_op(op_t op, logic [VAL_W-1:0] v);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= v;
		do @(posedge clk); while (!s_tready);
		gap = calm ? 0 : gap_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] cap);
		wait_until_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_capacity(int'(cap));
		sb.cap_writes++;
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int unsigned      push_pct;
		logic [CAP_W-1:0] cap;
		op_t              op;

		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset capacity: both ends, extreme values, removals on empty.
		send_op(OP_POP_FRONT, 32'hffff_ffff);
		send_op(OP_POP_BACK, 32'h1234_5678);
		send_op(OP_PUSH_FRONT, 32'h8000_0000);
		send_op(OP_PUSH_BACK, 32'h7fff_ffff);
		send_op(OP_PUSH_FRONT, 32'hffff_ffff);
		send_op(OP_PUSH_BACK, 32'h0000_0000);
		send_op(OP_POP_BACK, 32'h0);
		send_op(OP_POP_FRONT, 32'h0);
		send_op(OP_POP_BACK, 32'h0);
		send_op(OP_POP_FRONT, 32'h0);
		send_op(OP_POP_FRONT, 32'h0);

		// A zero capacity leaves a single slot: nothing fits.
		write_capacity(4'd0);
		send_op(OP_PUSH_FRONT, 32'hdead_beef);
		send_op(OP_PUSH_BACK, 32'hdead_beef);
		send_op(OP_POP_FRONT, 32'h0);
		send_op(OP_POP_BACK, 32'h0);

		write_capacity(4'd1);
		send_op(OP_PUSH_BACK, 32'h5a5a_5a5a);
		send_op(OP_PUSH_FRONT, 32'h1111_1111);
		send_op(OP_PUSH_BACK, 32'h2222_2222);
		send_op(OP_POP_FRONT, 32'h0);
		send_op(OP_PUSH_FRONT, 32'ha5a5_a5a5);
		send_op(OP_POP_BACK, 32'h0);

		// A capacity write throws away whatever is still stored.
		send_op(OP_PUSH_BACK, 32'h0000_0001);
		write_capacity(4'd2);
		send_op(OP_POP_FRONT, 32'h0);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: cap = 4'd15;
				1: cap = 4'd0;
				2: cap = 4'd1;
				default: cap = CAP_W'($urandom_range(0, 15));
			endcase
			calm = (ph % 5 == 3);
			write_capacity(cap);
			push_pct = 80;
			for (int i = 0; i < PHASE_OPS; i++) begin
				// Alternate filling and emptying runs so both limits are hit.
				if (i % 20 == 0)
					push_pct = (push_pct == 80) ? 20 : 80;
				if (ph % 4 == 1 && i == PHASE_OPS / 2)
					wait_until_drained();
				if ($urandom_range(0, 99) < push_pct)
					op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
				else
					op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
				send_op(op, pick_value());
			end
		end

		calm = 1'b0;
		wait_until_drained();
		repeat (5) @(posedge clk);

		$display("Checked %0d result beats across %0d capacity writes.",
			sb.checked, sb.cap_writes);
		$display("Refused inserts on a full deque: %0d, refused removals on an empty one: %0d.",
			sb.full_seen, sb.empty_seen);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/cdq_pkg.sv
hdl/cdq_cell.sv
hdl/circular_deque_unit.sv
tb/circular_deque_unit_tb.sv
